/* hdl/smseg_pkg.sv */
// Shared types and constants for the send message segmenter.
// No dependencies; compiled first.
`default_nettype none
package smseg_pkg;

   localparam int KIND_W    = 2;
   localparam int LEN_W     = 19;
   localparam int IMM_W     = 32;
   localparam int OPC_W     = 3;
   localparam int PSN_W     = 24;
   localparam int OFF_W     = 18;
   localparam int MTU_W     = 13;
   localparam int PAD_W     = 2;
   localparam int PKTS_W    = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 24;

   localparam int MAX_SEGMENTS_DEF = 64;

   // request kinds; the last two are dropped without a trace
   localparam logic [KIND_W-1:0] KIND_SEND     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEND_IMM = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

   // packet opcodes
   localparam logic [OPC_W-1:0] OP_FIRST    = 3'd0;
   localparam logic [OPC_W-1:0] OP_MIDDLE   = 3'd1;
   localparam logic [OPC_W-1:0] OP_LAST     = 3'd2;
   localparam logic [OPC_W-1:0] OP_LAST_IMM = 3'd3;
   localparam logic [OPC_W-1:0] OP_ONLY     = 3'd4;
   localparam logic [OPC_W-1:0] OP_ONLY_IMM = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MTU = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PSN = 1'b1;

   localparam logic [MTU_W-1:0] MTU_MIN   = 13'd256;
   localparam logic [MTU_W-1:0] MTU_MAX   = 13'd4096;
   localparam logic [MTU_W-1:0] MTU_RESET = 13'd1024;

   typedef struct packed {
      logic [MTU_W-1:0] mtu;        // clamped path MTU
      logic             psn_load;
      logic [PSN_W-1:0] psn_value;
   } csr_ctl_type;

   typedef struct packed {
      logic [OPC_W-1:0]  packet_opcode;
      logic [PSN_W-1:0]  sequence_number;
      logic [OFF_W-1:0]  payload_offset;
      logic [MTU_W-1:0]  payload_length;
      logic [PAD_W-1:0]  pad_bytes;
      logic              solicited_flag;
      logic              ack_wanted;
      logic              carries_immediate;
      logic [IMM_W-1:0]  immediate_out;
      logic [PKTS_W-1:0] message_packets;
      logic              last_of_message;
      logic              too_long;
   } rsp_payload_type;

endpackage
`default_nettype wire

/* hdl/smseg_if.sv */
// Request and response channel interfaces (valid/ready plus payload).
// Depends on smseg_pkg.
`default_nettype none
interface smseg_req_if;
   import smseg_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] request_kind;
   logic [LEN_W-1:0]  message_length;
   logic              solicited_event;
   logic [IMM_W-1:0]  immediate_value;

   modport source (output valid, request_kind, message_length, solicited_event,
                   immediate_value, input ready);
   modport sink   (input valid, request_kind, message_length, solicited_event,
                   immediate_value, output ready);
endinterface

interface smseg_rsp_if;
   import smseg_pkg::*;
   logic              valid;
   logic              ready;
   logic [OPC_W-1:0]  packet_opcode;
   logic [PSN_W-1:0]  sequence_number;
   logic [OFF_W-1:0]  payload_offset;
   logic [MTU_W-1:0]  payload_length;
   logic [PAD_W-1:0]  pad_bytes;
   logic              solicited_flag;
   logic              ack_wanted;
   logic              carries_immediate;
   logic [IMM_W-1:0]  immediate_out;
   logic [PKTS_W-1:0] message_packets;
   logic              last_of_message;
   logic              too_long;

   modport source (output valid, packet_opcode, sequence_number, payload_offset,
                   payload_length, pad_bytes, solicited_flag, ack_wanted,
                   carries_immediate, immediate_out, message_packets,
                   last_of_message, too_long, input ready);
   modport sink   (input valid, packet_opcode, sequence_number, payload_offset,
                   payload_length, pad_bytes, solicited_flag, ack_wanted,
                   carries_immediate, immediate_out, message_packets,
                   last_of_message, too_long, output ready);
endinterface
`default_nettype wire

/* hdl/send_message_segmenter.sv */
// Send message segmenter, top level.
// Packet counting runs first through the shared subtractor, then descriptors
// go out one per cycle while rsp ready is high.
// req ready is low from acceptance until the last descriptor is registered.
// Reset: mtu 1024, PSN 0, no response pending. Depends on smseg_pkg, smseg_if.
`default_nettype none
module send_message_segmenter #(
   parameter int MAX_SEGMENTS = smseg_pkg::MAX_SEGMENTS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   smseg_req_if.sink                               req_chan,
   smseg_rsp_if.source                             rsp_chan,
   input  wire logic                               csr_write_enable,
   input  wire logic [smseg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [smseg_pkg::CSR_DAT_W-1:0]    csr_write_data
);
   import smseg_pkg::*;

   csr_ctl_type ctl;

   smseg_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .ctl          (ctl)
   );

   smseg_core #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .ctl   (ctl)
   );

endmodule
`default_nettype wire

/* hdl/smseg_csr.sv */
// Configuration registers: path MTU (clamped to 256..4096) and PSN load strobe.
// Depends on smseg_pkg.
`default_nettype none
module smseg_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               write_enable,
   input  wire logic [smseg_pkg::CSR_IDX_W-1:0]    index,
   input  wire logic [smseg_pkg::CSR_DAT_W-1:0]    write_data,
   output smseg_pkg::csr_ctl_type                  ctl
);
   import smseg_pkg::*;

   logic [MTU_W-1:0] mtu_ff, mtu_in;

   always_comb begin
      mtu_in = mtu_ff;
      if (write_enable && index == REG_MTU) begin
         mtu_in = write_data[MTU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff <= MTU_RESET;
      end else begin
         mtu_ff <= mtu_in;
      end
   end

   always_comb begin
      if (mtu_ff < MTU_MIN) begin
         ctl.mtu = MTU_MIN;
      end else if (mtu_ff > MTU_MAX) begin
         ctl.mtu = MTU_MAX;
      end else begin
         ctl.mtu = mtu_ff;
      end
      ctl.psn_load  = write_enable && index == REG_PSN;
      ctl.psn_value = write_data[PSN_W-1:0];
   end

endmodule
`default_nettype wire

/* hdl/smseg_core.sv */
// Segmentation sequencer: one shared subtract/compare unit first counts the
// packets of a request, then walks the message emitting descriptors.
// Depends on smseg_pkg and smseg_if.
`default_nettype none
module smseg_core #(
   parameter int MAX_SEGMENTS = smseg_pkg::MAX_SEGMENTS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   smseg_req_if.sink                   req,
   smseg_rsp_if.source                 rsp,
   input  wire smseg_pkg::csr_ctl_type ctl
);
   import smseg_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   localparam logic [PKTS_W-1:0] MAX_PKTS = PKTS_W'(MAX_SEGMENTS);

   logic [1:0]        state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [PKTS_W-1:0] cnt_ff, cnt_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic              sol_ff, sol_in;
   logic [IMM_W-1:0]  imm_ff, imm_in;
   logic              with_imm_ff, with_imm_in;
   logic              first_ff, first_in;
   logic [PSN_W-1:0]  psn_ff, psn_in;
   rsp_payload_type   out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   // shared unit: remaining bytes minus MTU
   logic [LEN_W:0]    sub;
   logic              gt;
   logic              load_ok;
   logic              last;
   logic [MTU_W-1:0]  plen;

   assign sub     = {1'b0, rem_ff} - {{(LEN_W + 1 - MTU_W){1'b0}}, ctl.mtu};
   assign gt      = !sub[LEN_W] && (sub[LEN_W-1:0] != '0);
   assign load_ok = !out_valid_ff || rsp.ready;
   assign last    = !gt;
   assign plen    = gt ? ctl.mtu : rem_ff[MTU_W-1:0];

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      sol_in       = sol_ff;
      imm_in       = imm_ff;
      with_imm_in  = with_imm_ff;
      first_in     = first_ff;
      psn_in       = psn_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid &&
                (req.request_kind == KIND_SEND || req.request_kind == KIND_SEND_IMM)) begin
               len_in      = req.message_length;
               rem_in      = req.message_length;
               sol_in      = req.solicited_event;
               imm_in      = req.immediate_value;
               with_imm_in = req.request_kind == KIND_SEND_IMM;
               cnt_in      = PKTS_W'(1);
               state_in    = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (gt) begin
               if (cnt_ff >= MAX_PKTS) begin
                  if (load_ok) begin
                     out_in                 = '0;
                     out_in.too_long        = 1'b1;
                     out_in.last_of_message = 1'b1;
                     out_valid_in           = 1'b1;
                     state_in               = ST_IDLE;
                  end
               end else begin
                  rem_in = sub[LEN_W-1:0];
                  cnt_in = cnt_ff + PKTS_W'(1);
               end
            end else begin
               // cnt_ff now holds the packet count
               rem_in   = len_ff;
               off_in   = '0;
               first_in = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               if (first_ff && last) begin
                  out_in.packet_opcode = with_imm_ff ? OP_ONLY_IMM : OP_ONLY;
               end else if (first_ff) begin
                  out_in.packet_opcode = OP_FIRST;
               end else if (last) begin
                  out_in.packet_opcode = with_imm_ff ? OP_LAST_IMM : OP_LAST;
               end else begin
                  out_in.packet_opcode = OP_MIDDLE;
               end
               out_in.sequence_number   = psn_ff;
               out_in.payload_offset    = off_ff;
               out_in.payload_length    = plen;
               out_in.pad_bytes         = last ? PAD_W'(2'd0 - plen[PAD_W-1:0]) : '0;
               out_in.solicited_flag    = last && sol_ff;
               out_in.ack_wanted        = last;
               out_in.carries_immediate = last && with_imm_ff;
               out_in.immediate_out     = (last && with_imm_ff) ? imm_ff : '0;
               out_in.message_packets   = cnt_ff;
               out_in.last_of_message   = last;
               out_in.too_long          = 1'b0;
               out_valid_in             = 1'b1;
               psn_in                   = psn_ff + PSN_W'(1);
               if (gt) begin
                  rem_in   = sub[LEN_W-1:0];
                  off_in   = off_ff + OFF_W'(ctl.mtu);
                  first_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ctl.psn_load) begin
         psn_in = ctl.psn_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         psn_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         psn_ff       <= psn_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      off_ff      <= off_in;
      sol_ff      <= sol_in;
      imm_ff      <= imm_in;
      with_imm_ff <= with_imm_in;
      first_ff    <= first_in;
      out_ff      <= out_in;
   end

   assign req.ready             = state_ff == ST_IDLE;
   assign rsp.valid             = out_valid_ff;
   assign rsp.packet_opcode     = out_ff.packet_opcode;
   assign rsp.sequence_number   = out_ff.sequence_number;
   assign rsp.payload_offset    = out_ff.payload_offset;
   assign rsp.payload_length    = out_ff.payload_length;
   assign rsp.pad_bytes         = out_ff.pad_bytes;
   assign rsp.solicited_flag    = out_ff.solicited_flag;
   assign rsp.ack_wanted        = out_ff.ack_wanted;
   assign rsp.carries_immediate = out_ff.carries_immediate;
   assign rsp.immediate_out     = out_ff.immediate_out;
   assign rsp.message_packets   = out_ff.message_packets;
   assign rsp.last_of_message   = out_ff.last_of_message;
   assign rsp.too_long          = out_ff.too_long;

   a_emit_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (cnt_ff != '0 && cnt_ff <= MAX_PKTS))
      else $error("packet count out of range while emitting");

   a_psn_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && load_ok && !ctl.psn_load)
      |=> psn_ff == PSN_W'($past(psn_ff) + PSN_W'(1)))
      else $error("PSN did not advance by one per descriptor");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.too_long)
      |-> (out_ff.message_packets == '0 && out_ff.sequence_number == '0
           && out_ff.last_of_message))
      else $error("error item carries descriptor fields");

   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT && !gt)
      |=> (state_ff == ST_EMIT && first_ff && off_ff == '0 && rem_ff == $past(len_ff)))
      else $error("emit phase did not start at message head");

endmodule
`default_nettype wire

/* dv/tb_send_message_segmenter.sv */
`timescale 1ns / 1ps
// Self-checking testbench for send_message_segmenter: directed script, then random phases.
// Depends on smseg_pkg, smseg_if and the RTL of send_message_segmenter.
module tb_send_message_segmenter;
   import smseg_pkg::*;

   localparam int unsigned ALIGN_MASK   = 3;
   localparam int unsigned DRAIN_CYCLES = 2 * MAX_SEGMENTS_DEF + 8;
   localparam int unsigned LIMIT        = 600000;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned PHASES       = 5;
   localparam int unsigned PHASE_ITEMS  = 40;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  len;
      logic              sol;
      logic [IMM_W-1:0]  imm;
   } send_wr_type;

   typedef enum logic [0:0] { ROW_SEND, ROW_WRITE } row_kind_type;

   typedef struct {
      row_kind_type           what;
      send_wr_type            wr;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DAT_W-1:0]   data;
      bit                     typed;
      rsp_payload_type        exp;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_write_data;

   smseg_req_if req_if ();
   smseg_rsp_if rsp_if ();

   send_message_segmenter dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and PSN counter
   logic [MTU_W-1:0] mtu_reg;
   logic [PSN_W-1:0] next_psn;

   rsp_payload_type expected_desc[$];
   script_row_type  script[$];

   int unsigned requests_sent, ignored_seen, rejected_seen, descriptors_checked;
   int unsigned reg_writes, mismatches;
   int unsigned cycle_count = 0;
   bit calm = 1'b0;
   bit send_quiet = 1'b0, recv_quiet = 1'b0;
   bit long_hold_req = 1'b0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[7:0] == 8'd0) begin
         send_quiet <= ($urandom_range(0, 3) == 0);
         recv_quiet <= ($urandom_range(0, 3) == 0);
      end
      if (cycle_count >= LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int unsigned clamped_mtu();
      int unsigned m;
      m = mtu_reg;
      if (m < MTU_MIN) m = MTU_MIN;
      else if (m > MTU_MAX) m = MTU_MAX;
      return m;
   endfunction

   // Splits one work request into descriptors; record=0 only advances the PSN.
   function automatic void segment_request(input send_wr_type wr, input bit record);
      int unsigned mtu, count, offset, remain, plen, k;
      rsp_payload_type d;
      bit last, with_imm;
      if (wr.kind != KIND_SEND && wr.kind != KIND_SEND_IMM) begin
         ignored_seen++;
         return;
      end
      with_imm = (wr.kind == KIND_SEND_IMM);
      mtu = clamped_mtu();
      count = (wr.len == 0) ? 1 : (wr.len + mtu - 1) / mtu;
      if (count > MAX_SEGMENTS_DEF) begin
         rejected_seen++;
         d = '0;
         d.last_of_message = 1'b1;
         d.too_long = 1'b1;
         if (record) expected_desc.insert(expected_desc.size(), d);
         return;
      end
      offset = 0;
      for (k = 0; k < count; k++) begin
         last = (k == count - 1);
         remain = wr.len - offset;
         plen = (remain < mtu) ? remain : mtu;
         d = '0;
         if (k == 0 && last) d.packet_opcode = with_imm ? OP_ONLY_IMM : OP_ONLY;
         else if (k == 0) d.packet_opcode = OP_FIRST;
         else if (last) d.packet_opcode = with_imm ? OP_LAST_IMM : OP_LAST;
         else d.packet_opcode = OP_MIDDLE;
         d.sequence_number = next_psn;
         d.payload_offset = OFF_W'(offset);
         d.payload_length = MTU_W'(plen);
         if (last) begin
            d.pad_bytes = PAD_W'((4 - (plen & ALIGN_MASK)) & ALIGN_MASK);
            d.solicited_flag = wr.sol;
            d.ack_wanted = 1'b1;
            d.carries_immediate = with_imm;
            d.immediate_out = with_imm ? wr.imm : '0;
            d.last_of_message = 1'b1;
         end
         d.message_packets = PKTS_W'(count);
         if (record) expected_desc.insert(expected_desc.size(), d);
         next_psn = next_psn + 1'b1;
         offset += plen;
      end
   endfunction

   function automatic send_wr_type make_wr(input logic [KIND_W-1:0] kind, input int unsigned len,
                                           input logic sol, input logic [IMM_W-1:0] imm);
      send_wr_type wr;
      wr.kind = kind;
      wr.len = LEN_W'(len);
      wr.sol = sol;
      wr.imm = imm;
      return wr;
   endfunction

   function automatic void add_send(input logic [KIND_W-1:0] kind, input int unsigned len,
                                    input logic sol, input logic [IMM_W-1:0] imm);
      script_row_type r;
      r.what = ROW_SEND;
      r.wr = make_wr(kind, len, sol, imm);
      r.idx = '0;
      r.data = '0;
      r.typed = 1'b0;
      r.exp = '0;
      script.insert(script.size(), r);
   endfunction

   function automatic void add_typed(input logic [KIND_W-1:0] kind, input int unsigned len,
                                     input logic sol, input logic [IMM_W-1:0] imm,
                                     input rsp_payload_type exp);
      add_send(kind, len, sol, imm);
      script[$].typed = 1'b1;
      script[$].exp = exp;
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DAT_W-1:0] data);
      script_row_type r;
      r.what = ROW_WRITE;
      r.wr = '0;
      r.idx = idx;
      r.data = data;
      r.typed = 1'b0;
      r.exp = '0;
      script.insert(script.size(), r);
   endfunction

   function automatic send_wr_type random_wr();
      int unsigned mtu, pick, len;
      logic [KIND_W-1:0] kind;
      mtu = clamped_mtu();
      kind = ($urandom_range(0, 99) < 8) ? KIND_W'($urandom_range(KIND_OTHER, KIND_SPARE))
                                         : KIND_W'($urandom_range(KIND_SEND, KIND_SEND_IMM));
      pick = $urandom_range(0, 99);
      if (pick < 50) len = $urandom_range(0, 3 * mtu);
      else if (pick < 65) len = $urandom_range(1, 8) * mtu + $urandom_range(0, 2) - 1;
      else if (pick < 75) len = $urandom_range(0, 7);
      else if (pick < 85) len = $urandom_range(3 * mtu, MAX_SEGMENTS_DEF * mtu);
      else if (pick < 95) len = $urandom_range(MAX_SEGMENTS_DEF * mtu + 1, (1 << LEN_W) - 1);
      else len = MAX_SEGMENTS_DEF * mtu + $urandom_range(0, 1);
      return make_wr(kind, len, 1'($urandom_range(0, 1)), $urandom);
   endfunction

   task automatic offer_request(input send_wr_type wr);
      req_if.request_kind    <= wr.kind;
      req_if.message_length  <= wr.len;
      req_if.solicited_event <= wr.sol;
      req_if.immediate_value <= wr.imm;
      req_if.valid           <= 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      requests_sent++;
   endtask

   task automatic maybe_pause();
      if (!calm && !send_quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid           <= 1'b0;
         req_if.request_kind    <= KIND_W'($urandom);
         req_if.message_length  <= LEN_W'($urandom);
         req_if.solicited_event <= 1'($urandom);
         req_if.immediate_value <= $urandom;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Registers only change with nothing in flight; ignored items leave no trace in the queue.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_desc.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == REG_MTU) mtu_reg = data[MTU_W-1:0];
      else next_psn = data[PSN_W-1:0];
      reg_writes++;
   endtask

   task automatic field_check(input string name, input logic [IMM_W-1:0] exp,
                              input logic [IMM_W-1:0] act);
      if (act !== exp) begin
         $error("%s: expected %0h, actual %0h", name, exp, act);
         mismatches++;
      end
   endtask

   task automatic check_descriptor(input rsp_payload_type act);
      rsp_payload_type exp;
      if (expected_desc.size() == 0) begin
         $error("descriptor with nothing expected: opcode %0d psn %0h",
                act.packet_opcode, act.sequence_number);
         mismatches++;
         return;
      end
      exp = expected_desc.pop_front();
      descriptors_checked++;
      field_check("packet_opcode", exp.packet_opcode, act.packet_opcode);
      field_check("sequence_number", exp.sequence_number, act.sequence_number);
      field_check("payload_offset", exp.payload_offset, act.payload_offset);
      field_check("payload_length", exp.payload_length, act.payload_length);
      field_check("pad_bytes", exp.pad_bytes, act.pad_bytes);
      field_check("solicited_flag", exp.solicited_flag, act.solicited_flag);
      field_check("ack_wanted", exp.ack_wanted, act.ack_wanted);
      field_check("carries_immediate", exp.carries_immediate, act.carries_immediate);
      field_check("immediate_out", exp.immediate_out, act.immediate_out);
      field_check("message_packets", exp.message_packets, act.message_packets);
      field_check("last_of_message", exp.last_of_message, act.last_of_message);
      field_check("too_long", exp.too_long, act.too_long);
   endtask

   // descriptor sink: checks, then picks ready for the next cycle
   initial begin
      rsp_payload_type act;
      int unsigned stall_left, hold_left;
      bit hold_done;
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            act.packet_opcode     = rsp_if.packet_opcode;
            act.sequence_number   = rsp_if.sequence_number;
            act.payload_offset    = rsp_if.payload_offset;
            act.payload_length    = rsp_if.payload_length;
            act.pad_bytes         = rsp_if.pad_bytes;
            act.solicited_flag    = rsp_if.solicited_flag;
            act.ack_wanted        = rsp_if.ack_wanted;
            act.carries_immediate = rsp_if.carries_immediate;
            act.immediate_out     = rsp_if.immediate_out;
            act.message_packets   = rsp_if.message_packets;
            act.last_of_message   = rsp_if.last_of_message;
            act.too_long          = rsp_if.too_long;
            check_descriptor(act);
         end
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (calm || recv_quiet) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // request source
   initial begin
      send_wr_type wr;
      int unsigned phase, counted;
      logic [CSR_DAT_W-1:0] mtu_pick, psn_pick;

      reset                  <= 1'b1;
      csr_write_enable       <= 1'b0;
      csr_index              <= '0;
      csr_write_data         <= '0;
      req_if.valid           <= 1'b0;
      req_if.request_kind    <= '0;
      req_if.message_length  <= '0;
      req_if.solicited_event <= 1'b0;
      req_if.immediate_value <= '0;
      mtu_reg  = MTU_RESET;
      next_psn = '0;

      // reset state: mtu 1024, PSN 0
      add_typed(KIND_SEND, 0, 1'b0, 32'h0,
         '{OP_ONLY, 24'h0, 18'd0, 13'd0, 2'd0, 1'b0, 1'b1, 1'b0, 32'h0, 7'd1, 1'b1, 1'b0});
      add_typed(KIND_SEND_IMM, 0, 1'b1, 32'hFFFF_FFFF,
         '{OP_ONLY_IMM, 24'h1, 18'd0, 13'd0, 2'd0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 7'd1,
           1'b1, 1'b0});
      add_typed(KIND_SEND, 1, 1'b0, 32'h1234_5678,
         '{OP_ONLY, 24'h2, 18'd0, 13'd1, 2'd3, 1'b0, 1'b1, 1'b0, 32'h0, 7'd1, 1'b1, 1'b0});
      add_send(KIND_OTHER, 100, 1'b1, 32'hDEAD_BEEF);
      add_send(KIND_SPARE, 0, 1'b0, 32'h0);
      add_typed(KIND_SEND, 65537, 1'b1, 32'h5555_5555, '{default: '0, last_of_message: 1'b1,
                                                         too_long: 1'b1});
      add_typed(KIND_SEND_IMM, (1 << LEN_W) - 1, 1'b1, 32'hAAAA_AAAA,
                '{default: '0, last_of_message: 1'b1, too_long: 1'b1});
      add_typed(KIND_SEND_IMM, 1024, 1'b1, 32'hA5A5_A5A5,
         '{OP_ONLY_IMM, 24'h3, 18'd0, 13'd1024, 2'd0, 1'b1, 1'b1, 1'b1, 32'hA5A5_A5A5, 7'd1,
           1'b1, 1'b0});
      add_send(KIND_SEND, 1025, 1'b1, 32'h0);
      add_send(KIND_SEND_IMM, 3000, 1'b0, 32'h0BAD_F00D);
      add_send(KIND_SEND, 65536, 1'b1, 32'h0);
      // MTU below the floor, PSN just short of the wrap
      add_write(REG_MTU, 24'd0);
      add_write(REG_PSN, 24'hFF_FFFE);
      add_send(KIND_SEND_IMM, 1000, 1'b1, 32'h8000_0001);
      add_typed(KIND_SEND, 16385, 1'b0, 32'h0, '{default: '0, last_of_message: 1'b1,
                                                 too_long: 1'b1});
      add_send(KIND_SEND, 16384, 1'b0, 32'h0);
      // all-ones data: only the low 13 bits land, then clamp to 4096
      add_write(REG_MTU, 24'hFF_FFFF);
      add_send(KIND_SEND_IMM, 262144, 1'b1, 32'h7FFF_FFFE);
      add_typed(KIND_SEND, 262145, 1'b1, 32'h0, '{default: '0, last_of_message: 1'b1,
                                                  too_long: 1'b1});
      add_send(KIND_SEND, 4097, 1'b0, 32'h0);
      add_write(REG_MTU, 24'd255);
      add_write(REG_PSN, 24'h00_0000);
      add_send(KIND_SEND, 257, 1'b1, 32'h0);
      add_write(REG_MTU, 24'd4097);
      add_send(KIND_SEND_IMM, 4096, 1'b0, 32'h1357_9BDF);
      add_write(REG_MTU, 24'd256);
      add_write(REG_PSN, 24'hAB_CDEF);
      add_typed(KIND_SEND, 3, 1'b0, 32'h0,
         '{OP_ONLY, 24'hAB_CDEF, 18'd0, 13'd3, 2'd1, 1'b0, 1'b1, 1'b0, 32'h0, 7'd1, 1'b1, 1'b0});
      add_write(REG_MTU, 24'd4096);
      add_send(KIND_SEND_IMM, 2, 1'b1, 32'h0);
      add_write(REG_MTU, 24'd1000);
      add_send(KIND_SEND, 2500, 1'b1, 32'h0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].what == ROW_WRITE) begin
            wait_idle();
            write_reg(script[i].idx, script[i].data);
         end else begin
            offer_request(script[i].wr);
            if (script[i].typed) begin
               expected_desc.insert(expected_desc.size(), script[i].exp);
               segment_request(script[i].wr, 1'b0);
            end else begin
               segment_request(script[i].wr, 1'b1);
            end
            maybe_pause();
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               mtu_pick = 24'd256;
               psn_pick = 24'hFF_FFF0;
            end
            1: begin
               mtu_pick = CSR_DAT_W'($urandom_range(MTU_MIN, MTU_MAX));
               psn_pick = CSR_DAT_W'($urandom_range(0, 24'hFF_FFFF));
            end
            2: begin
               mtu_pick = 24'd4096;
               psn_pick = 24'hFF_FFFF;
            end
            3: begin
               mtu_pick = CSR_DAT_W'($urandom_range(0, 24'hFF_FFFF));
               psn_pick = CSR_DAT_W'($urandom_range(0, 24'hFF_FFFF));
            end
            default: begin
               mtu_pick = CSR_DAT_W'($urandom_range(MTU_MIN, MTU_MAX));
               psn_pick = CSR_DAT_W'(24'hFF_FFFF - $urandom_range(0, 100));
            end
         endcase
         write_reg(REG_MTU, mtu_pick);
         write_reg(REG_PSN, psn_pick);
         // sink holds off for a long stretch while requests keep coming
         if (phase == 1) long_hold_req = 1'b1;
         if (phase == PHASES - 1) calm = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            wr = random_wr();
            offer_request(wr);
            segment_request(wr, 1'b1);
            if (wr.kind == KIND_SEND || wr.kind == KIND_SEND_IMM) counted++;
            maybe_pause();
         end
      end

      wait_idle();
      $display("Run covered %0d requests (%0d ignored kinds, %0d too long), %0d register writes,",
               requests_sent, ignored_seen, rejected_seen, reg_writes);
      $display("with %0d descriptors checked across clamped, wrapping and extreme settings.",
               descriptors_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
